FILE: sv/linked_thread_queue_manager_unit_defines.svh
// Assertion macros for the linked thread queue manager.
// Included by the RTL file that asserts; relies on clk_i and rst_ni in scope.
`ifndef LINKED_THREAD_QUEUE_MANAGER_UNIT_DEFINES_SVH
`define LINKED_THREAD_QUEUE_MANAGER_UNIT_DEFINES_SVH

// Plain property, sampled on clk_i, off during reset.
`define LTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define LTQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LTQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ltq_pkg.sv
// Shared types and constants for the linked thread queue manager.
// No dependencies; used by ltq_ctrl, ltq_dp and the top level.
`default_nettype none

package ltq_pkg;

  localparam int unsigned THREADS_DEF = 64;

  typedef enum logic [1:0] {
    MODE_ENQ = 2'd0,
    MODE_DEQ = 2'd1,
    MODE_REM = 2'd2
  } ltq_mode_e;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } ltq_status_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_LOOKUP,
    S_ENQ_LINK,
    S_ENQ_TERM,
    S_DEQ_CHK,
    S_DEQ_FIX,
    S_REM_START,
    S_REM_CHK,
    S_REM_ADV,
    S_REM_LINK,
    S_REM_CLR
  } ltq_state_e;

  // Datapath micro-operations, one per cycle.
  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_CLEAR,
    UOP_LOAD,
    UOP_READ_HT,
    UOP_ENQ_LINK,
    UOP_ENQ_TERM,
    UOP_DEQ_LAST,
    UOP_DEQ_STEP,
    UOP_DEQ_FIX,
    UOP_WALK_START,
    UOP_WALK_READ,
    UOP_WALK_ADV,
    UOP_REM_READ,
    UOP_REM_LINK,
    UOP_REM_CLR
  } ltq_uop_e;

  typedef struct packed {
    ltq_uop_e    uop;
    logic        finish;  // present a result beat next cycle
    logic        pop;     // result carries the head read at lookup
    ltq_status_e status;
  } ltq_cmd_t;

  typedef struct packed {
    logic mode_enq;
    logic mode_deq;
    logic mode_rem;
    logic q_ok;
    logic t_ok;
    logic head_null;
    logic head_is_tail;
    logic walk_end;
    logic walk_hit;
    logic clr_last;
  } ltq_sts_t;

endpackage

`default_nettype wire

FILE: sv/ltq_ctrl.sv
// Sequencer for the linked thread queue manager.
// Depends on ltq_pkg; drives ltq_dp through ltq_cmd_t.
`default_nettype none

module ltq_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire ltq_pkg::ltq_sts_t sts_i,
  output ltq_pkg::ltq_cmd_t     cmd_o,
  output logic                  busy_o
);
  import ltq_pkg::*;

  ltq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o.uop    = UOP_NOP;
    cmd_o.finish = 1'b0;
    cmd_o.pop    = 1'b0;
    cmd_o.status = STAT_DONE;
    unique case (state_q)
      S_INIT: begin
        cmd_o.uop = UOP_CLEAR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.uop = UOP_LOAD;
          state_d   = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_d = S_IDLE;
        if (sts_i.mode_enq) begin
          if (sts_i.q_ok && sts_i.t_ok) begin
            cmd_o.uop = UOP_READ_HT;
            state_d   = S_ENQ_LINK;
          end else begin
            cmd_o.finish = 1'b1;
          end
        end else if (sts_i.mode_deq) begin
          if (sts_i.q_ok) begin
            cmd_o.uop = UOP_READ_HT;
            state_d   = S_DEQ_CHK;
          end else begin
            cmd_o.finish = 1'b1;
            cmd_o.status = STAT_EMPTY;
          end
        end else if (sts_i.mode_rem) begin
          if (sts_i.q_ok && sts_i.t_ok) begin
            cmd_o.uop = UOP_READ_HT;
            state_d   = S_REM_START;
          end else begin
            cmd_o.finish = 1'b1;
            cmd_o.status = STAT_NOT_FOUND;
          end
        end else begin
          cmd_o.finish = 1'b1;
        end
      end
      S_ENQ_LINK: begin
        cmd_o.uop = UOP_ENQ_LINK;
        state_d   = S_ENQ_TERM;
      end
      S_ENQ_TERM: begin
        cmd_o.uop    = UOP_ENQ_TERM;
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      S_DEQ_CHK: begin
        if (sts_i.head_null) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = STAT_EMPTY;
          state_d      = S_IDLE;
        end else if (sts_i.head_is_tail) begin
          cmd_o.uop    = UOP_DEQ_LAST;
          cmd_o.finish = 1'b1;
          cmd_o.pop    = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.uop = UOP_DEQ_STEP;
          state_d   = S_DEQ_FIX;
        end
      end
      S_DEQ_FIX: begin
        cmd_o.uop    = UOP_DEQ_FIX;
        cmd_o.finish = 1'b1;
        cmd_o.pop    = 1'b1;
        state_d      = S_IDLE;
      end
      S_REM_START: begin
        cmd_o.uop = UOP_WALK_START;
        state_d   = S_REM_CHK;
      end
      S_REM_CHK: begin
        if (sts_i.walk_end) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = STAT_NOT_FOUND;
          state_d      = S_IDLE;
        end else if (sts_i.walk_hit) begin
          cmd_o.uop = UOP_REM_READ;
          state_d   = S_REM_LINK;
        end else begin
          cmd_o.uop = UOP_WALK_READ;
          state_d   = S_REM_ADV;
        end
      end
      S_REM_ADV: begin
        cmd_o.uop = UOP_WALK_ADV;
        state_d   = S_REM_CHK;
      end
      S_REM_LINK: begin
        cmd_o.uop = UOP_REM_LINK;
        state_d   = S_REM_CLR;
      end
      S_REM_CLR: begin
        cmd_o.uop    = UOP_REM_CLR;
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

FILE: sv/ltq_dp.sv
// Datapath of the linked thread queue manager: head/tail/next/prev tables,
// walk cursor and result registers. Depends on ltq_pkg; driven by ltq_ctrl.
`default_nettype none

module ltq_dp #(
  parameter  int unsigned THREADS = ltq_pkg::THREADS_DEF,
  localparam int unsigned IW      = $clog2(THREADS + 1),
  localparam int unsigned AW      = $clog2(THREADS)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ltq_pkg::ltq_cmd_t cmd_i,
  output ltq_pkg::ltq_sts_t      sts_o,
  input  wire logic [1:0]        mode_i,
  input  wire logic [IW-1:0]     queue_id_i,
  input  wire logic [AW-1:0]     thread_id_i,
  output logic                   done_o,
  output logic [IW-1:0]          popped_thread_o,
  output logic [1:0]             status_o
);
  import ltq_pkg::*;

  localparam logic [IW-1:0] NULL_ID = IW'(THREADS);

  // tables
  logic [IW-1:0] head_mem [0:THREADS];
  logic [IW-1:0] tail_mem [0:THREADS];
  logic [IW-1:0] next_mem [0:THREADS-1];
  logic [IW-1:0] prev_mem [0:THREADS-1];

  // latched item
  logic [1:0]    mode_q;
  logic [IW-1:0] q_q;
  logic [AW-1:0] t_q;
  logic [IW-1:0] t_ext;

  // registered read data
  logic [IW-1:0] head_rd_q, tail_rd_q, next_rd_q, prev_rd_q;

  // walk cursor
  logic [IW-1:0] cur_q, cur_d, steps_q, steps_d;

  // init sweep
  logic [IW-1:0] clr_cnt_q, clr_cnt_d;

  // result beat
  logic          done_q;
  logic [IW-1:0] popped_q;
  logic [1:0]    status_q;

  // table ports
  logic          head_we, tail_we, next_we, prev_we;
  logic [IW-1:0] head_wa, tail_wa;
  logic [AW-1:0] next_wa, prev_wa;
  logic [IW-1:0] head_wd, tail_wd, next_wd, prev_wd;
  logic          ht_re, next_re, prev_re;
  logic [AW-1:0] next_ra, prev_ra;

  assign t_ext = IW'(t_q);

  always_comb begin
    head_we   = 1'b0;
    tail_we   = 1'b0;
    next_we   = 1'b0;
    prev_we   = 1'b0;
    head_wa   = q_q;
    tail_wa   = q_q;
    next_wa   = t_q;
    prev_wa   = t_q;
    head_wd   = NULL_ID;
    tail_wd   = NULL_ID;
    next_wd   = NULL_ID;
    prev_wd   = NULL_ID;
    ht_re     = 1'b0;
    next_re   = 1'b0;
    prev_re   = 1'b0;
    next_ra   = t_q;
    prev_ra   = t_q;
    cur_d     = cur_q;
    steps_d   = steps_q;
    clr_cnt_d = clr_cnt_q;
    unique case (cmd_i.uop)
      UOP_NOP, UOP_LOAD: begin
      end
      UOP_CLEAR: begin
        head_we   = 1'b1;
        tail_we   = 1'b1;
        head_wa   = clr_cnt_q;
        tail_wa   = clr_cnt_q;
        next_we   = (clr_cnt_q < NULL_ID);
        prev_we   = (clr_cnt_q < NULL_ID);
        next_wa   = clr_cnt_q[AW-1:0];
        prev_wa   = clr_cnt_q[AW-1:0];
        clr_cnt_d = clr_cnt_q + IW'(1);
      end
      UOP_READ_HT: begin
        ht_re = 1'b1;
      end
      UOP_ENQ_LINK: begin
        tail_we = 1'b1;
        tail_wd = t_ext;
        prev_we = 1'b1;
        if (tail_rd_q == NULL_ID) begin
          head_we = 1'b1;
          head_wd = t_ext;
        end else begin
          next_we = 1'b1;
          next_wa = tail_rd_q[AW-1:0];
          next_wd = t_ext;
          prev_wd = tail_rd_q;
        end
      end
      UOP_ENQ_TERM: begin
        next_we = 1'b1;
      end
      UOP_DEQ_LAST: begin
        head_we = 1'b1;
        tail_we = 1'b1;
        next_we = 1'b1;
        prev_we = 1'b1;
        next_wa = head_rd_q[AW-1:0];
        prev_wa = head_rd_q[AW-1:0];
      end
      UOP_DEQ_STEP: begin
        next_re = 1'b1;
        next_ra = head_rd_q[AW-1:0];
        prev_we = 1'b1;
        prev_wa = head_rd_q[AW-1:0];
      end
      UOP_DEQ_FIX: begin
        head_we = 1'b1;
        head_wd = next_rd_q;
        prev_we = (next_rd_q != NULL_ID);
        prev_wa = next_rd_q[AW-1:0];
        next_we = 1'b1;
        next_wa = head_rd_q[AW-1:0];
      end
      UOP_WALK_START: begin
        cur_d   = head_rd_q;
        steps_d = '0;
      end
      UOP_WALK_READ: begin
        next_re = 1'b1;
        next_ra = cur_q[AW-1:0];
      end
      UOP_WALK_ADV: begin
        cur_d   = next_rd_q;
        steps_d = steps_q + IW'(1);
      end
      UOP_REM_READ: begin
        next_re = 1'b1;
        prev_re = 1'b1;
      end
      UOP_REM_LINK: begin
        // unlink: neighbors point past the removed thread
        head_we = (head_rd_q == t_ext);
        head_wd = next_rd_q;
        tail_we = (tail_rd_q == t_ext);
        tail_wd = prev_rd_q;
        prev_we = (next_rd_q != NULL_ID);
        prev_wa = next_rd_q[AW-1:0];
        prev_wd = prev_rd_q;
        next_we = (prev_rd_q != NULL_ID);
        next_wa = prev_rd_q[AW-1:0];
        next_wd = next_rd_q;
      end
      UOP_REM_CLR: begin
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // tables: one write and one registered read per cycle each
  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (ht_re)   head_rd_q <= head_mem[q_q];
  end

  always_ff @(posedge clk_i) begin
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    if (ht_re)   tail_rd_q <= tail_mem[q_q];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (next_re) next_rd_q <= next_mem[next_ra];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (prev_re) prev_rd_q <= prev_mem[prev_ra];
  end

  // item and cursor
  always_ff @(posedge clk_i) begin
    if (cmd_i.uop == UOP_LOAD) begin
      mode_q <= mode_i;
      q_q    <= queue_id_i;
      t_q    <= thread_id_i;
    end
    cur_q    <= cur_d;
    steps_q  <= steps_d;
    popped_q <= cmd_i.pop ? head_rd_q : NULL_ID;
    status_q <= cmd_i.status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
      done_q    <= cmd_i.finish;
    end
  end

  assign sts_o.mode_enq     = (mode_q == MODE_ENQ);
  assign sts_o.mode_deq     = (mode_q == MODE_DEQ);
  assign sts_o.mode_rem     = (mode_q == MODE_REM);
  assign sts_o.q_ok         = (q_q <= NULL_ID);
  assign sts_o.t_ok         = (t_ext < NULL_ID);
  assign sts_o.head_null    = (head_rd_q == NULL_ID);
  assign sts_o.head_is_tail = (head_rd_q == tail_rd_q);
  assign sts_o.walk_end     = (cur_q == NULL_ID) || (steps_q == NULL_ID);
  assign sts_o.walk_hit     = (cur_q == t_ext);
  assign sts_o.clr_last     = (clr_cnt_q == NULL_ID);

  assign done_o          = done_q;
  assign popped_thread_o = popped_q;
  assign status_o        = status_q;

endmodule

`default_nettype wire

FILE: sv/linked_thread_queue_manager_unit.sv
// Top level of the linked thread queue manager.
// Depends on ltq_pkg, ltq_ctrl, ltq_dp and the assertion macro header.
//
// Usage:
//   Command channel: drive mode_i / queue_id_i / thread_id_i with start high;
//   the beat is taken at the rising edge where start is high and busy is low.
//   One item is worked at a time.
//   Result channel: done_o is high for exactly one cycle with popped_thread_o
//   and status_o. The receiver cannot stall; the beat must be taken then.
//   busy is already low during the done_o cycle, so a new command may be
//   taken at the edge that ends it.
// Steps from accept until the sequencer is idle again:
//   enqueue: lookup, link, terminate; dequeue: lookup, check, then a fix
//   step unless the queue is empty or holds one entry; remove: lookup,
//   start, a check and an advance per link walked, then link and clear,
//   or not found at the check after the last link (the walk stops after
//   THREADS links); out-of-range ids and unused mode 3 end at lookup.
//   Every link lookup is a registered table read, and each walked link
//   passes a check state, which issues the read, and an advance state.
// Reset: head/tail/next/prev tables are swept to null one entry per cycle,
//   with busy high; no command is taken until the sweep is over.
`default_nettype none

`include "linked_thread_queue_manager_unit_defines.svh"

module linked_thread_queue_manager_unit #(
  parameter  int unsigned THREADS = ltq_pkg::THREADS_DEF,
  localparam int unsigned IW      = $clog2(THREADS + 1),
  localparam int unsigned AW      = $clog2(THREADS)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [1:0]    mode_i,
  input  wire logic [IW-1:0] queue_id_i,
  input  wire logic [AW-1:0] thread_id_i,
  output logic               done_o,
  output logic [IW-1:0]      popped_thread_o,
  output logic [1:0]         status_o
);
  import ltq_pkg::*;

  localparam logic [IW-1:0] NULL_ID = IW'(THREADS);

  ltq_cmd_t cmd;
  ltq_sts_t sts;

  // sequencer: one micro-op per cycle
  ltq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // tables, walk cursor and result registers
  ltq_dp #(
    .THREADS (THREADS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .mode_i          (mode_i),
    .queue_id_i      (queue_id_i),
    .thread_id_i     (thread_id_i),
    .done_o          (done_o),
    .popped_thread_o (popped_thread_o),
    .status_o        (status_o)
  );

  // result beat only ever ends an item in flight
  `LTQ_ASSERT_IMP(a_done_idle, done_o, !busy, "result beat while still busy")
  `LTQ_ASSERT_IMP(a_done_after_work, done_o, $past(busy), "result beat without an item")
  // an accepted command always occupies the sequencer next cycle
  `LTQ_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted command left idle")
  // failed operations never report a thread
  `LTQ_ASSERT_IMP(a_err_no_pop, done_o && (status_o != STAT_DONE),
    popped_thread_o == NULL_ID, "error result carries a thread id")

endmodule

`default_nettype wire
